>>> rtl/iopzs_pkg.sv
// Shared types and constants for the I/O request page mapper with zone statistics.
package iopzs_pkg;

  localparam int ZONE_COUNT_DEF = 32768;
  localparam int ZONE_SHIFT_DEF = 16;

  localparam int OFFSET_W = 43;
  localparam int LENGTH_W = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W = OFFSET_W - PAGE_SHIFT;
  localparam int SECTOR_SHIFT = 9;
  localparam int SECTOR_W = LENGTH_W - SECTOR_SHIFT;
  localparam int SECTORS_PER_BLOCK = 8;
  localparam int BLOCK_SHIFT = 3;
  localparam int BLOCK_W = SECTOR_W + 1 - BLOCK_SHIFT;
  localparam int SIZE_W = 13;
  localparam int COUNT_W = 32;
  localparam int SUM_W = 48;
  localparam int ZCOUNT_W = 16;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET = 13'd256;
  // 5120 * 1024 * 256 pages
  localparam logic [PAGE_W-1:0] WRAP_PAGES = 31'd1342177280;

  localparam int QUEUE_DEPTH = 4;

  // zone map row: one bit for "touched", one for "written"
  localparam int ZMAP_W = 2;
  localparam int ZMAP_SEEN = 0;
  localparam int ZMAP_WRITTEN = 1;

  typedef struct packed {
    logic                op;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LENGTH_W-1:0] byte_length;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   page_address;
    logic [SIZE_W-1:0]   size_blocks;
    logic                is_write;
    logic                address_wrapped;
    logic                size_clipped;
    logic [COUNT_W-1:0]  total_requests;
    logic [COUNT_W-1:0]  total_writes;
    logic [SUM_W-1:0]    total_blocks;
    logic [SUM_W-1:0]    write_blocks;
    logic [ZCOUNT_W-1:0] zones_touched;
    logic [ZCOUNT_W-1:0] zones_written;
  } out_item_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [PAGE_W-1:0]  page_address;
    logic [SIZE_W-1:0]  size_blocks;
    logic [BLOCK_W-1:0] blocks;
    logic               is_write;
    logic               address_wrapped;
    logic               size_clipped;
  } q_entry_t;

endpackage

>>> rtl/iopzs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iopzs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/iopzs_front.sv
// Front end: size limit register, page mapping, block rounding, wrap and clamp.
module iopzs_front #(
  parameter int ZONE_COUNT = iopzs_pkg::ZONE_COUNT_DEF,
  parameter int ZONE_SHIFT = iopzs_pkg::ZONE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iopzs_pkg::SIZE_W-1:0]    cfg_data,
  input  iopzs_pkg::in_item_t             in_data,
  output iopzs_pkg::q_entry_t             q_entry,
  output logic [$clog2(ZONE_COUNT)-1:0]   q_zone,
  output logic                            q_zone_ok
);

  localparam int ZAW = $clog2(ZONE_COUNT);

  logic [iopzs_pkg::SIZE_W-1:0]     size_limit_r;
  logic [iopzs_pkg::PAGE_W-1:0]     page_raw;
  logic [iopzs_pkg::PAGE_W-1:0]     zone_full;
  logic [iopzs_pkg::SECTOR_W-1:0]   sectors;
  logic [iopzs_pkg::SECTOR_W:0]     sectors_rnd;
  logic [iopzs_pkg::BLOCK_W-1:0]    blocks;
  logic                             wrapped;
  logic                             clipped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r <= iopzs_pkg::SIZE_LIMIT_RESET;
    end else if (cfg_valid) begin
      size_limit_r <= cfg_data;
    end
  end

  always_comb begin
    page_raw  = in_data.byte_offset[iopzs_pkg::OFFSET_W-1:iopzs_pkg::PAGE_SHIFT];
    zone_full = page_raw >> ZONE_SHIFT;
    q_zone_ok = zone_full < iopzs_pkg::PAGE_W'(ZONE_COUNT);
    q_zone    = zone_full[ZAW-1:0];

    // whole sectors, then round up to 4 KiB blocks; no sectors gives no blocks
    sectors     = in_data.byte_length[iopzs_pkg::LENGTH_W-1:iopzs_pkg::SECTOR_SHIFT];
    sectors_rnd = {1'b0, sectors}
                + (iopzs_pkg::SECTOR_W+1)'(iopzs_pkg::SECTORS_PER_BLOCK - 1);
    blocks      = sectors_rnd[iopzs_pkg::SECTOR_W:iopzs_pkg::BLOCK_SHIFT];

    wrapped = page_raw > iopzs_pkg::WRAP_PAGES;
    clipped = blocks > iopzs_pkg::BLOCK_W'(size_limit_r);

    q_entry.page_address    = wrapped ? page_raw - iopzs_pkg::WRAP_PAGES : page_raw;
    q_entry.size_blocks     = clipped ? size_limit_r : blocks[iopzs_pkg::SIZE_W-1:0];
    q_entry.blocks          = blocks;
    q_entry.is_write        = in_data.op;
    q_entry.address_wrapped = wrapped;
    q_entry.size_clipped    = clipped;
  end

endmodule

>>> rtl/iopzs_queue.sv
// Short FIFO of classified requests between the front end and the statistics engine.
module iopzs_queue #(
  parameter int ZONE_COUNT = iopzs_pkg::ZONE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  iopzs_pkg::q_entry_t           push_entry,
  input  logic [$clog2(ZONE_COUNT)-1:0] push_zone,
  input  logic                          push_zone_ok,
  output logic                          full,
  input  logic                          pop,
  output logic                          empty,
  output iopzs_pkg::q_entry_t           head_entry,
  output logic [$clog2(ZONE_COUNT)-1:0] head_zone,
  output logic                          head_zone_ok
);

  localparam int ZAW = $clog2(ZONE_COUNT);
  localparam int DEPTH = iopzs_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  iopzs_pkg::q_entry_t entry_r   [DEPTH];
  logic [ZAW-1:0]      zone_r    [DEPTH];
  logic                zone_ok_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]       count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r]   <= push_entry;
      zone_r[wr_ptr_r]    <= push_zone;
      zone_ok_r[wr_ptr_r] <= push_zone_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign full         = count_r == CW'(DEPTH);
  assign empty        = count_r == '0;
  assign head_entry   = entry_r[rd_ptr_r];
  assign head_zone    = zone_r[rd_ptr_r];
  assign head_zone_ok = zone_ok_r[rd_ptr_r];

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on a lone push");

endmodule

>>> rtl/iopzs_back.sv
// Statistics engine: zone map read-modify-write, saturating totals, result register.
module iopzs_back #(
  parameter int ZONE_COUNT = iopzs_pkg::ZONE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  iopzs_pkg::q_entry_t           q_entry,
  input  logic [$clog2(ZONE_COUNT)-1:0] q_zone,
  input  logic                          q_zone_ok,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output iopzs_pkg::out_item_t          out_data
);

  localparam int ZAW = $clog2(ZONE_COUNT);
  localparam int ZMW = iopzs_pkg::ZMAP_W;

  // clearing pass
  logic                 clr_active_r;
  logic [ZAW-1:0]       clr_addr_r;

  // map stage
  logic                 b_valid_r;
  iopzs_pkg::q_entry_t  b_entry_r;
  logic [ZAW-1:0]       b_zone_r;
  logic                 b_zone_ok_r;
  logic                 b_fire;

  // last map row written, for a read that raced the write
  logic                 fwd_valid_r;
  logic [ZAW-1:0]       fwd_zone_r;
  logic [ZMW-1:0]       fwd_bits_r;

  logic [iopzs_pkg::COUNT_W-1:0]  req_cnt_r, req_cnt_nxt;
  logic [iopzs_pkg::COUNT_W-1:0]  wr_cnt_r, wr_cnt_nxt;
  logic [iopzs_pkg::SUM_W-1:0]    blk_sum_r, blk_sum_nxt;
  logic [iopzs_pkg::SUM_W-1:0]    wblk_sum_r, wblk_sum_nxt;
  logic [iopzs_pkg::ZCOUNT_W-1:0] seen_cnt_r, seen_cnt_nxt;
  logic [iopzs_pkg::ZCOUNT_W-1:0] wzone_cnt_r, wzone_cnt_nxt;
  logic [iopzs_pkg::SUM_W:0]      blk_sum_ext, wblk_sum_ext;

  logic                 out_valid_r;
  iopzs_pkg::out_item_t out_data_r;

  logic                 ram_we, ram_re;
  logic [ZAW-1:0]       ram_waddr;
  logic [ZMW-1:0]       ram_wdata, ram_rdata;
  logic [ZMW-1:0]       cur_bits, upd_bits;
  logic                 new_seen, new_written;

  assign b_fire = b_valid_r && (!out_valid_r || out_ready);
  assign q_pop  = !q_empty && !clr_active_r && (!b_valid_r || b_fire);
  assign ram_re = q_pop;
  assign clearing = clr_active_r;

  always_comb begin
    cur_bits = (fwd_valid_r && fwd_zone_r == b_zone_r) ? fwd_bits_r : ram_rdata;
    new_seen    = b_zone_ok_r && !cur_bits[iopzs_pkg::ZMAP_SEEN];
    new_written = b_zone_ok_r && b_entry_r.is_write && !cur_bits[iopzs_pkg::ZMAP_WRITTEN];
    upd_bits = cur_bits;
    upd_bits[iopzs_pkg::ZMAP_SEEN] = 1'b1;
    if (b_entry_r.is_write) begin
      upd_bits[iopzs_pkg::ZMAP_WRITTEN] = 1'b1;
    end

    ram_we    = clr_active_r || (b_fire && b_zone_ok_r);
    ram_waddr = clr_active_r ? clr_addr_r : b_zone_r;
    ram_wdata = clr_active_r ? '0 : upd_bits;

    req_cnt_nxt = (&req_cnt_r) ? req_cnt_r : req_cnt_r + 1'b1;
    blk_sum_ext = {1'b0, blk_sum_r} + (iopzs_pkg::SUM_W+1)'(b_entry_r.blocks);
    blk_sum_nxt = blk_sum_ext[iopzs_pkg::SUM_W] ? '1 : blk_sum_ext[iopzs_pkg::SUM_W-1:0];

    wr_cnt_nxt   = wr_cnt_r;
    wblk_sum_ext = {1'b0, wblk_sum_r} + (iopzs_pkg::SUM_W+1)'(b_entry_r.blocks);
    wblk_sum_nxt = wblk_sum_r;
    if (b_entry_r.is_write) begin
      wr_cnt_nxt   = (&wr_cnt_r) ? wr_cnt_r : wr_cnt_r + 1'b1;
      wblk_sum_nxt = wblk_sum_ext[iopzs_pkg::SUM_W] ? '1
                   : wblk_sum_ext[iopzs_pkg::SUM_W-1:0];
    end

    seen_cnt_nxt  = (new_seen && !(&seen_cnt_r)) ? seen_cnt_r + 1'b1 : seen_cnt_r;
    wzone_cnt_nxt = (new_written && !(&wzone_cnt_r)) ? wzone_cnt_r + 1'b1 : wzone_cnt_r;
  end

  iopzs_ram #(
    .WIDTH (ZMW),
    .DEPTH (ZONE_COUNT)
  ) u_zone_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_zone),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      b_valid_r    <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      req_cnt_r    <= '0;
      wr_cnt_r     <= '0;
      blk_sum_r    <= '0;
      wblk_sum_r   <= '0;
      seen_cnt_r   <= '0;
      wzone_cnt_r  <= '0;
    end else begin
      if (clr_active_r) begin
        if (clr_addr_r == ZAW'(ZONE_COUNT - 1)) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
      if (q_pop) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire && b_zone_ok_r) begin
        fwd_valid_r <= 1'b1;
      end
      if (b_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_fire) begin
        req_cnt_r   <= req_cnt_nxt;
        wr_cnt_r    <= wr_cnt_nxt;
        blk_sum_r   <= blk_sum_nxt;
        wblk_sum_r  <= wblk_sum_nxt;
        seen_cnt_r  <= seen_cnt_nxt;
        wzone_cnt_r <= wzone_cnt_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_entry_r   <= q_entry;
      b_zone_r    <= q_zone;
      b_zone_ok_r <= q_zone_ok;
    end
    if (b_fire && b_zone_ok_r) begin
      fwd_zone_r <= b_zone_r;
      fwd_bits_r <= upd_bits;
    end
    if (b_fire) begin
      out_data_r.page_address    <= b_entry_r.page_address;
      out_data_r.size_blocks     <= b_entry_r.size_blocks;
      out_data_r.is_write        <= b_entry_r.is_write;
      out_data_r.address_wrapped <= b_entry_r.address_wrapped;
      out_data_r.size_clipped    <= b_entry_r.size_clipped;
      out_data_r.total_requests  <= req_cnt_nxt;
      out_data_r.total_writes    <= wr_cnt_nxt;
      out_data_r.total_blocks    <= blk_sum_nxt;
      out_data_r.write_blocks    <= wblk_sum_nxt;
      out_data_r.zones_touched   <= seen_cnt_nxt;
      out_data_r.zones_written   <= wzone_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_read_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!ram_re && !b_valid_r))
    else $error("zone map read while clearing");

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && b_zone_ok_r) |=> (fwd_valid_r && fwd_zone_r == $past(b_zone_r)))
    else $error("forward register missed a zone map write");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire |=> (out_valid_r && out_data_r.total_requests != '0))
    else $error("fired request produced no result");

endmodule

>>> rtl/io_request_page_map_zone_stats.sv
// Top level of the I/O request page mapper with running zone statistics.
// One request is taken per transfer on in_*: op, byte offset and byte length. Each request
// gives exactly one result on out_*: the 4 KiB page address (wrapped once by 5 TiB when it
// lies strictly above), the size in 4 KiB blocks clamped to size_limit_blocks, the flags,
// and the saturating running totals including this request. Sustained rate is one request
// per clock while out_ready stays high. A transfer writes the queue; the request then moves
// to the map stage as the zone map RAM read is registered, and then to the result
// register, which raises out_valid. After reset a clearing pass zeroes the zone map, one
// zone per cycle, so in_ready stays low until the pass ends; cfg writes are taken at any
// time and are registered into the size limit.
module io_request_page_map_zone_stats #(
  parameter int ZONE_COUNT = iopzs_pkg::ZONE_COUNT_DEF,
  parameter int ZONE_SHIFT = iopzs_pkg::ZONE_SHIFT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration: size_limit_blocks
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [iopzs_pkg::SIZE_W-1:0] cfg_data,
  // requests
  input  logic                         in_valid,
  output logic                         in_ready,
  input  iopzs_pkg::in_item_t          in_data,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output iopzs_pkg::out_item_t         out_data
);

  localparam int ZAW = $clog2(ZONE_COUNT);

  iopzs_pkg::q_entry_t f_entry, h_entry;
  logic [ZAW-1:0]      f_zone, h_zone;
  logic                f_zone_ok, h_zone_ok;
  logic                q_full, q_empty, q_pop, q_push;
  logic                clearing;

  // front end classifies on the fly; the transfer writes straight into the queue
  iopzs_front #(
    .ZONE_COUNT (ZONE_COUNT),
    .ZONE_SHIFT (ZONE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .q_entry   (f_entry),
    .q_zone    (f_zone),
    .q_zone_ok (f_zone_ok)
  );

  // no requests during the zone map clearing pass
  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;

  iopzs_queue #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (q_push),
    .push_entry   (f_entry),
    .push_zone    (f_zone),
    .push_zone_ok (f_zone_ok),
    .full         (q_full),
    .pop          (q_pop),
    .empty        (q_empty),
    .head_entry   (h_entry),
    .head_zone    (h_zone),
    .head_zone_ok (h_zone_ok)
  );

  // back end: zone map read-modify-write, totals and the result register
  iopzs_back #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (h_entry),
    .q_zone    (h_zone),
    .q_zone_ok (h_zone_ok),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/io_request_page_map_zone_stats_tb.sv
// Self-checking testbench for the I/O request page mapper with zone statistics.
module io_request_page_map_zone_stats_tb;

  // Run length and timing knobs
  localparam int SEG_ITEMS    = 320;     // random requests per phase, six phases
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_GAP    = 6;       // idle wait after the last result has come back
  localparam int LIMIT_CYCLES = 400000;  // clearing pass plus slowest run, several times over

  localparam logic [iopzs_pkg::SUM_W-1:0] COUNT_TOP  = 48'h0000_FFFF_FFFF;
  localparam logic [iopzs_pkg::SUM_W-1:0] SUM_TOP    = 48'hFFFF_FFFF_FFFF;
  localparam logic [iopzs_pkg::SUM_W-1:0] ZCOUNT_TOP = 48'h0000_0000_FFFF;

  // Predictor and store of expected results, one entry per accepted request.
  class zone_stats_scoreboard;
    bit                            seen_map[iopzs_pkg::ZONE_COUNT_DEF];
    bit                            written_map[iopzs_pkg::ZONE_COUNT_DEF];
    logic [iopzs_pkg::SUM_W-1:0]   req_cnt, wr_cnt, blk_sum, wr_blk_sum, seen_zones, wr_zones;
    logic [iopzs_pkg::SIZE_W-1:0]  limit;
    iopzs_pkg::out_item_t          expected_q[$];
    int                            errors, checked, wraps, clips, shorts;

    function new();
      foreach (seen_map[i]) begin
        seen_map[i]    = 1'b0;
        written_map[i] = 1'b0;
      end
      req_cnt    = '0;
      wr_cnt     = '0;
      blk_sum    = '0;
      wr_blk_sum = '0;
      seen_zones = '0;
      wr_zones   = '0;
      limit      = iopzs_pkg::SIZE_LIMIT_RESET;
      errors     = 0;
      checked    = 0;
      wraps      = 0;
      clips      = 0;
      shorts     = 0;
    endfunction

    function logic [iopzs_pkg::SUM_W-1:0] sat_add(logic [iopzs_pkg::SUM_W-1:0] acc,
                                                  logic [iopzs_pkg::SUM_W-1:0] inc,
                                                  logic [iopzs_pkg::SUM_W-1:0] top);
      if (inc >= top || acc >= top - inc) return top;
      return acc + inc;
    endfunction

    // Map one request and fold it into the running totals
    function void note_request(iopzs_pkg::in_item_t r);
      logic [iopzs_pkg::PAGE_W-1:0]   page;
      logic [iopzs_pkg::SECTOR_W-1:0] sectors;
      logic [iopzs_pkg::BLOCK_W-1:0]  blocks;
      int unsigned                    zone;
      iopzs_pkg::out_item_t           e;
      page    = r.byte_offset[iopzs_pkg::OFFSET_W-1:iopzs_pkg::PAGE_SHIFT];
      sectors = r.byte_length[iopzs_pkg::LENGTH_W-1:iopzs_pkg::SECTOR_SHIFT];
      // short length gives no blocks rather than an underflow
      blocks  = (sectors == '0) ? '0
              : iopzs_pkg::BLOCK_W'(((sectors - 1'b1) >> iopzs_pkg::BLOCK_SHIFT) + 1'b1);
      if (sectors == '0) shorts++;
      // zone comes from the page before any wrap
      zone    = 32'(page >> iopzs_pkg::ZONE_SHIFT_DEF);

      req_cnt = sat_add(req_cnt, 48'd1, COUNT_TOP);
      blk_sum = sat_add(blk_sum, iopzs_pkg::SUM_W'(blocks), SUM_TOP);
      if (zone < iopzs_pkg::ZONE_COUNT_DEF && !seen_map[zone]) begin
        seen_map[zone] = 1'b1;
        seen_zones     = sat_add(seen_zones, 48'd1, ZCOUNT_TOP);
      end
      if (r.op) begin
        wr_cnt     = sat_add(wr_cnt, 48'd1, COUNT_TOP);
        wr_blk_sum = sat_add(wr_blk_sum, iopzs_pkg::SUM_W'(blocks), SUM_TOP);
        if (zone < iopzs_pkg::ZONE_COUNT_DEF && !written_map[zone]) begin
          written_map[zone] = 1'b1;
          wr_zones          = sat_add(wr_zones, 48'd1, ZCOUNT_TOP);
        end
      end

      e.page_address    = page;
      e.address_wrapped = 1'b0;
      if (page > iopzs_pkg::WRAP_PAGES) begin
        e.page_address    = page - iopzs_pkg::WRAP_PAGES;
        e.address_wrapped = 1'b1;
        wraps++;
      end
      e.size_blocks  = blocks[iopzs_pkg::SIZE_W-1:0];
      e.size_clipped = 1'b0;
      if (blocks > iopzs_pkg::BLOCK_W'(limit)) begin
        e.size_blocks  = limit;
        e.size_clipped = 1'b1;
        clips++;
      end
      e.is_write       = r.op;
      e.total_requests = req_cnt[iopzs_pkg::COUNT_W-1:0];
      e.total_writes   = wr_cnt[iopzs_pkg::COUNT_W-1:0];
      e.total_blocks   = blk_sum;
      e.write_blocks   = wr_blk_sum;
      e.zones_touched  = seen_zones[iopzs_pkg::ZCOUNT_W-1:0];
      e.zones_written  = wr_zones[iopzs_pkg::ZCOUNT_W-1:0];
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [iopzs_pkg::SUM_W-1:0] got,
                logic [iopzs_pkg::SUM_W-1:0] want);
      errors++;
      $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               checked, what, got, want);
    endtask

    task field(string name, logic [iopzs_pkg::SUM_W-1:0] got,
               logic [iopzs_pkg::SUM_W-1:0] want);
      if (got !== want) report(name, got, want);
    endtask

    task check_result(iopzs_pkg::out_item_t got);
      iopzs_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        report("result with nothing outstanding, total_requests",
               iopzs_pkg::SUM_W'(got.total_requests), '0);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      field("page_address",    iopzs_pkg::SUM_W'(got.page_address),
                               iopzs_pkg::SUM_W'(e.page_address));
      field("size_blocks",     iopzs_pkg::SUM_W'(got.size_blocks),
                               iopzs_pkg::SUM_W'(e.size_blocks));
      field("is_write",        iopzs_pkg::SUM_W'(got.is_write),
                               iopzs_pkg::SUM_W'(e.is_write));
      field("address_wrapped", iopzs_pkg::SUM_W'(got.address_wrapped),
                               iopzs_pkg::SUM_W'(e.address_wrapped));
      field("size_clipped",    iopzs_pkg::SUM_W'(got.size_clipped),
                               iopzs_pkg::SUM_W'(e.size_clipped));
      field("total_requests",  iopzs_pkg::SUM_W'(got.total_requests),
                               iopzs_pkg::SUM_W'(e.total_requests));
      field("total_writes",    iopzs_pkg::SUM_W'(got.total_writes),
                               iopzs_pkg::SUM_W'(e.total_writes));
      field("total_blocks",    got.total_blocks,    e.total_blocks);
      field("write_blocks",    got.write_blocks,    e.write_blocks);
      field("zones_touched",   iopzs_pkg::SUM_W'(got.zones_touched),
                               iopzs_pkg::SUM_W'(e.zones_touched));
      field("zones_written",   iopzs_pkg::SUM_W'(got.zones_written),
                               iopzs_pkg::SUM_W'(e.zones_written));
    endtask
  endclass

  // DUT signals; the out_ready process starts it low
  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [iopzs_pkg::SIZE_W-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  iopzs_pkg::in_item_t          in_data;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  iopzs_pkg::out_item_t         out_data;

  zone_stats_scoreboard sb;

  // Shared run state: idle percentages, hold-off trigger, transfer counts
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int unsigned accepted_reqs = 0;
  int unsigned hold_at       = 32'hFFFF_FFFF;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned cycles        = 0;

  // zones that random traffic keeps coming back to, so reads and writes meet
  logic [14:0] hot_zone[8];
  logic [iopzs_pkg::SIZE_W-1:0] cur_limit;

  io_request_page_map_zone_stats i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.expected_q.size());
      $display("[io_request_page_map_zone_stats] ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once the chosen
  // request count is reached so that the queue fills and in_ready drops.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_reqs >= hold_at) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: every transfer is sampled at the edge that completes it. The
  // result is checked before the request is noted; a result can never belong
  // to a request taken on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) begin
        sb.note_request(in_data);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (cfg_valid && cfg_ready) sb.limit = cfg_data;
    end
  end

  function automatic iopzs_pkg::in_item_t make_req(logic op,
                                                   logic [iopzs_pkg::PAGE_W-1:0] page,
                                                   logic [iopzs_pkg::PAGE_SHIFT-1:0] low,
                                                   logic [iopzs_pkg::LENGTH_W-1:0] len);
    iopzs_pkg::in_item_t r;
    r.op          = op;
    r.byte_offset = {page, low};
    r.byte_length = len;
    return r;
  endfunction

  // Random request: offsets lean on hot zones, the wrap boundary and the
  // ends of the page range; lengths lean on short ones and on sizes around
  // the current clamp limit and the 512-byte and 4 KiB edges.
  function automatic iopzs_pkg::in_item_t random_request(logic [iopzs_pkg::SIZE_W-1:0] lim);
    iopzs_pkg::in_item_t          r;
    logic [iopzs_pkg::PAGE_W-1:0] page;
    longint                       k;
    longint                       len;
    int unsigned                  pick;
    int                           deltas[6];
    deltas = '{-512, -1, 0, 1, 511, 512};
    r.op = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 30)
      page = {hot_zone[$urandom_range(7)], 16'($urandom)};
    else if (pick < 50)
      page = iopzs_pkg::WRAP_PAGES + iopzs_pkg::PAGE_W'($urandom_range(4))
           - iopzs_pkg::PAGE_W'(2);
    else if (pick < 58)
      page = $urandom_range(1) ? ~iopzs_pkg::PAGE_W'($urandom_range(3))
                               : iopzs_pkg::PAGE_W'($urandom_range(3));
    else
      page = iopzs_pkg::PAGE_W'($urandom);
    r.byte_offset = {page, 12'($urandom)};

    pick = $urandom_range(99);
    if (pick < 15) begin
      len = longint'($urandom_range(511));
    end else if (pick < 40) begin
      k   = ($urandom_range(1) ? longint'(lim) : longint'($urandom_range(16)))
            + longint'($urandom_range(2)) - 1;
      len = k * 4096 + deltas[$urandom_range(5)];
    end else if (pick < 60) begin
      len = longint'($urandom_range(65535));
    end else begin
      len = longint'($urandom);
    end
    r.byte_length = len[31:0];
    return r;
  endfunction

  // One request transfer, with random idle cycles in front of it. Valid is
  // only ever raised in a step where it was not also lowered.
  task automatic push_request(input iopzs_pkg::in_item_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Register write, only issued while the block is idle
  task automatic write_limit(input logic [iopzs_pkg::SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit  = v;
    @(posedge clk);
  endtask

  initial begin
    logic [iopzs_pkg::SIZE_W-1:0] limits[6];
    int                           seg;
    sb        = new();
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    cur_limit = iopzs_pkg::SIZE_LIMIT_RESET;
    hot_zone[0] = '0;
    hot_zone[1] = '1;
    for (int i = 2; i < 8; i++) hot_zone[i] = 15'($urandom);
    limits = '{13'd1, 13'd4096, 13'd0, 13'h1FFF, 13'($urandom_range(1, 4096)),
               iopzs_pkg::SIZE_LIMIT_RESET};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset limit; the clearing pass holds them off
    in_idle_pct  = 24;
    out_idle_pct = 65;
    // short lengths, then the 512-byte and 4 KiB edges
    push_request(make_req(1'b0, '0, '0, 32'd0));
    push_request(make_req(1'b1, '0, '0, 32'd511));
    push_request(make_req(1'b0, '0, 12'hFFF, 32'd512));
    push_request(make_req(1'b1, 31'd1, '0, 32'd4096));
    push_request(make_req(1'b0, 31'd2, '0, 32'd4097));
    push_request(make_req(1'b1, 31'd3, '0, 32'd4608));
    // sizes at and just above the clamp limit, then the largest length
    push_request(make_req(1'b0, 31'd4, '0, 32'd256 * 32'd4096));
    push_request(make_req(1'b1, 31'd5, '0, 32'd257 * 32'd4096));
    push_request(make_req(1'b1, 31'd6, '0, 32'hFFFF_FFFF));
    // page exactly at the wrap point stays, one above wraps, top page wraps
    push_request(make_req(1'b0, iopzs_pkg::WRAP_PAGES, '0, 32'd8192));
    push_request(make_req(1'b1, iopzs_pkg::WRAP_PAGES, 12'hFFF, 32'd8192));
    push_request(make_req(1'b0, iopzs_pkg::WRAP_PAGES + 31'd1, '0, 32'd8192));
    push_request(make_req(1'b1, '1, 12'hFFF, 32'hFFFF_FFFF));
    push_request(make_req(1'b0, iopzs_pkg::WRAP_PAGES - 31'd1, 12'hFFF, 32'd0));
    // zone bookkeeping: read a zone, write it twice, then write a fresh one
    push_request(make_req(1'b0, {15'd5, 16'h1234}, 12'h010, 32'd1024));
    push_request(make_req(1'b1, {15'd5, 16'hFFFF}, 12'h020, 32'd1024));
    push_request(make_req(1'b1, {15'd5, 16'h0000}, 12'h030, 32'd1024));
    push_request(make_req(1'b1, {15'd6, 16'h0000}, 12'h040, 32'd1024));
    push_request(make_req(1'b0, {15'd0, 16'hFFFF}, 12'hFFF, 32'd600));
    push_request(make_req(1'b1, {15'h7FFF, 16'h0000}, '0, 32'd3000));
    drain();

    // Random phases: each starts idle with a fresh limit. Idling goes
    // sender-light/receiver-heavy, then the reverse, then none at all.
    for (seg = 0; seg < 6; seg++) begin
      in_idle_pct  = (seg < 2) ? 24 : (seg < 4) ? 65 : 0;
      out_idle_pct = (seg < 2) ? 65 : (seg < 4) ? 24 : 0;
      write_limit(limits[seg]);
      // long hold-off while the sender streams without gaps
      if (seg == 4) hold_at = accepted_reqs + 40;
      repeat (SEG_ITEMS) push_request(random_request(cur_limit));
      drain();
    end

    $display("covered %0d requests (%0d results checked) over limits 256/1/4096/0/8191/%0d/256",
             accepted_reqs, sb.checked, limits[4]);
    $display("%0d wrapped addresses, %0d clamped sizes, %0d short lengths, %0d zones touched",
             sb.wraps, sb.clips, sb.shorts, sb.seen_zones);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[io_request_page_map_zone_stats] OK");
    end else begin
      $display("[io_request_page_map_zone_stats] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/iopzs_pkg.sv
rtl/iopzs_ram.sv
rtl/iopzs_front.sv
rtl/iopzs_queue.sv
rtl/iopzs_back.sv
rtl/io_request_page_map_zone_stats.sv
verif/io_request_page_map_zone_stats_tb.sv
